// File: rtl/escf_pkg.sv
`timescale 1ns / 1ps
// escf_pkg: shared types and constants for the escaped frame receiver.
// No dependencies; imported by every module of the block.
package escf_pkg;

	localparam logic [7:0] BYTE_START = 8'hFE;
	localparam logic [7:0] BYTE_END   = 8'hFF;
	localparam logic [7:0] ESC_FF     = 8'hFD;
	localparam logic [7:0] ESC_FE     = 8'hFC;
	localparam logic [7:0] HEADER_LEN = 8'd4;
	localparam logic [7:0] DECODE_LIM = 8'd128;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_ESC   = 3'd2,
		ST_LEN_MISM  = 3'd3,
		ST_NO_HEADER = 3'd4,
		ST_OVERFLOW  = 3'd5
	} escf_status_t;

	typedef struct packed {
		logic         is_end;
		logic [7:0]   data_byte;
		logic [7:0]   src_port;
		logic [7:0]   dst_port;
		logic [15:0]  remote_addr;
		logic [6:0]   body_len;
		escf_status_t status;
	} escf_result_t;

endpackage

// File: rtl/escf_if.sv
`timescale 1ns / 1ps
// escf_rx_if / escf_res_if: valid-ready channels of the escaped frame receiver.
// No dependencies.
interface escf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface escf_res_if;
	logic        valid;
	logic        ready;
	logic        is_end;
	logic [7:0]  data_byte;
	logic [7:0]  src_port;
	logic [7:0]  dst_port;
	logic [15:0] remote_addr;
	logic [6:0]  body_len;
	logic [2:0]  status;

	modport source (output valid, output is_end, output data_byte, output src_port,
		output dst_port, output remote_addr, output body_len, output status,
		input ready);
	modport sink (input valid, input is_end, input data_byte, input src_port,
		input dst_port, input remote_addr, input body_len, input status,
		output ready);
endinterface

// File: rtl/escaped_frame_receiver.sv
`timescale 1ns / 1ps
// escaped_frame_receiver: top level of the byte-stuffed frame deframer.
// Depends on escf_pkg, escf_if (escf_rx_if, escf_res_if) and escf_core.
//
//  channel | dir | payload                                   | notes
//  rx      | in  | rx_byte                                   | one link byte per request
//  res     | out | is_end, data_byte, src_port, dst_port,    | payload byte or
//          |     | remote_addr, body_len, status             | frame-end status
//
// One byte per cycle while res does not stall; a byte's result passes the input
// register, then is decoded into the output register.
// Bytes that yield no result (idle, start, length, header, escapes) leave
// the output register untouched.
// When res stalls, the input register holds and rx.ready drops once it is full.
// arst_n clears both valid flags and all frame state (idle).
module escaped_frame_receiver import escf_pkg::*; #(
	parameter int MAX_FRAME = 128
) (
	input logic        clk,
	input logic        arst_n,
	escf_rx_if.sink    rx,
	escf_res_if.source res
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	escf_result_t out_q;
	logic         adv;
	logic         step;
	logic         hit;
	escf_result_t result_d;

	assign adv      = !out_valid_q || res.ready;
	assign rx.ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	escf_core #(.MAX_FRAME(MAX_FRAME)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.hit     (hit),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			out_q <= result_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.is_end      = out_q.is_end;
	assign res.data_byte   = out_q.data_byte;
	assign res.src_port    = out_q.src_port;
	assign res.dst_port    = out_q.dst_port;
	assign res.remote_addr = out_q.remote_addr;
	assign res.body_len    = out_q.body_len;
	assign res.status      = out_q.status;

endmodule

// File: rtl/escf_core.sv
`timescale 1ns / 1ps
// escf_core: deframer state and per-byte unescape / header / status decode.
// Depends on escf_pkg.
module escf_core import escf_pkg::*; #(
	parameter int MAX_FRAME = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	output logic         hit,
	output escf_result_t result
);

	localparam logic [7:0] MaxFrameC = 8'(MAX_FRAME);

	logic        in_frame_q, in_frame_n;
	logic        esc_pend_q, esc_pend_n;
	logic        esc_err_q, esc_err_n;
	logic [7:0]  raw_cnt_q, raw_cnt_n;
	logic [7:0]  dec_cnt_q, dec_cnt_n;
	logic [7:0]  decl_len_q, decl_len_n;
	logic [7:0]  src_q, src_n;
	logic [7:0]  dst_q, dst_n;
	logic [15:0] addr_q, addr_n;

	logic        take;
	logic [7:0]  take_val;

	always_comb begin
		in_frame_n = in_frame_q;
		esc_pend_n = esc_pend_q;
		esc_err_n  = esc_err_q;
		raw_cnt_n  = raw_cnt_q;
		dec_cnt_n  = dec_cnt_q;
		decl_len_n = decl_len_q;
		src_n      = src_q;
		dst_n      = dst_q;
		addr_n     = addr_q;
		take       = 1'b0;
		take_val   = byte_in;
		hit        = 1'b0;
		result     = '0;

		if (step) begin
			if (!in_frame_q) begin
				if (byte_in == BYTE_START) begin
					in_frame_n = 1'b1;
					esc_pend_n = 1'b0;
					esc_err_n  = 1'b0;
					raw_cnt_n  = 8'd1;
					dec_cnt_n  = '0;
					decl_len_n = '0;
					src_n      = '0;
					dst_n      = '0;
					addr_n     = '0;
				end
			end else if (raw_cnt_q >= MaxFrameC) begin
				// frame too long: drop this byte and abort
				in_frame_n    = 1'b0;
				hit           = 1'b1;
				result.is_end = 1'b1;
				result.status = ST_OVERFLOW;
			end else begin
				raw_cnt_n = raw_cnt_q + 8'd1;
				if (byte_in == BYTE_END) begin
					hit           = 1'b1;
					in_frame_n    = 1'b0;
					result.is_end = 1'b1;
					if (raw_cnt_q < 8'd3)
						result.status = ST_SHORT;
					else if (esc_err_q || esc_pend_q)
						result.status = ST_BAD_ESC;
					else if (dec_cnt_q > DECODE_LIM || dec_cnt_q != decl_len_q)
						result.status = ST_LEN_MISM;
					else if (dec_cnt_q < HEADER_LEN)
						result.status = ST_NO_HEADER;
					else begin
						result.status      = ST_OK;
						result.src_port    = src_q;
						result.dst_port    = dst_q;
						result.remote_addr = addr_q;
						result.body_len    = 7'(dec_cnt_q - HEADER_LEN);
					end
				end else if (raw_cnt_q == 8'd1) begin
					decl_len_n = byte_in;
				end else if (!(esc_err_q || dec_cnt_q > DECODE_LIM)) begin
					if (esc_pend_q) begin
						esc_pend_n = 1'b0;
						if (byte_in == ESC_FF) begin
							take     = 1'b1;
							take_val = 8'hFF;
						end else if (byte_in == ESC_FE) begin
							take     = 1'b1;
							take_val = 8'hFE;
						end else begin
							esc_err_n = 1'b1;
						end
					end else if (byte_in == BYTE_START) begin
						esc_pend_n = 1'b1;
					end else begin
						take = 1'b1;
					end
				end
			end

			if (take) begin
				if (dec_cnt_q >= DECODE_LIM) begin
					dec_cnt_n = DECODE_LIM + 8'd1;
				end else begin
					dec_cnt_n = dec_cnt_q + 8'd1;
					if (dec_cnt_q == 8'd0)
						src_n = take_val;
					else if (dec_cnt_q == 8'd1)
						dst_n = take_val;
					else if (dec_cnt_q == 8'd2)
						addr_n = {addr_q[15:8], take_val};
					else if (dec_cnt_q == 8'd3)
						addr_n = {take_val, addr_q[7:0]};
					else begin
						hit              = 1'b1;
						result.data_byte = take_val;
						result.status    = ST_OK;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			esc_err_q  <= 1'b0;
			raw_cnt_q  <= '0;
			dec_cnt_q  <= '0;
			decl_len_q <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			addr_q     <= '0;
		end else begin
			in_frame_q <= in_frame_n;
			esc_pend_q <= esc_pend_n;
			esc_err_q  <= esc_err_n;
			raw_cnt_q  <= raw_cnt_n;
			dec_cnt_q  <= dec_cnt_n;
			decl_len_q <= decl_len_n;
			src_q      <= src_n;
			dst_q      <= dst_n;
			addr_q     <= addr_n;
		end
	end

endmodule

// File: rtl/escf_checker.sv
`timescale 1ns / 1ps
// escf_checker: port-level checks for escaped_frame_receiver, bound below.
// Depends on escf_pkg.
module escf_checker import escf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        is_end,
	input logic [7:0]  data_byte,
	input logic [7:0]  src_port,
	input logic [7:0]  dst_port,
	input logic [15:0] remote_addr,
	input logic [6:0]  body_len,
	input logic [2:0]  status
);

	// stalled result must hold
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(is_end) && $stable(data_byte)
			&& $stable(status))
		else $error("result changed while stalled");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_end |-> status == ST_OK && src_port == 8'd0 && dst_port == 8'd0
			&& remote_addr == 16'd0 && body_len == 7'd0)
		else $error("payload request carries status or header");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_end && status != ST_OK |-> data_byte == 8'd0 && src_port == 8'd0
			&& dst_port == 8'd0 && remote_addr == 16'd0 && body_len == 7'd0)
		else $error("failed frame leaks header or data");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_end && status == ST_OK |-> body_len <= 7'd124 && data_byte == 8'd0)
		else $error("ok frame with bad length");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= ST_OVERFLOW)
		else $error("undefined status code");

endmodule

bind escaped_frame_receiver escf_checker u_escf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.is_end      (res.is_end),
	.data_byte   (res.data_byte),
	.src_port    (res.src_port),
	.dst_port    (res.dst_port),
	.remote_addr (res.remote_addr),
	.body_len    (res.body_len),
	.status      (res.status)
);

// File: tb/sv/frame_result_checker.sv
`timescale 1ns / 1ps
// frame_result_checker: watches both channels of the escaped frame receiver and
// predicts its results from the accepted link bytes. Depends on escf_pkg.
module frame_result_checker import escf_pkg::*; #(
	parameter int MAX_FRAME = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        res_is_end,
	input  logic [7:0]  res_data_byte,
	input  logic [7:0]  res_src_port,
	input  logic [7:0]  res_dst_port,
	input  logic [15:0] res_remote_addr,
	input  logic [6:0]  res_body_len,
	input  logic [2:0]  res_status,
	output int          fail_count,
	output int          n_pending
);

	// deframer state mirror
	bit          in_frame;
	bit          esc_pend;
	bit          esc_err;
	logic [7:0]  raw_cnt;
	logic [7:0]  dec_cnt;
	logic [7:0]  decl_len;
	logic [7:0]  src_reg;
	logic [7:0]  dst_reg;
	logic [15:0] addr_reg;

	escf_result_t predicted_results[$];
	escf_result_t want;
	escf_result_t fresh;
	bit           emits;

	initial begin
		fail_count = 0;
		n_pending  = 0;
	end

	task automatic clear_frame();
		esc_pend = 1'b0;
		esc_err  = 1'b0;
		raw_cnt  = '0;
		dec_cnt  = '0;
		decl_len = '0;
		src_reg  = '0;
		dst_reg  = '0;
		addr_reg = '0;
	endtask

	task automatic absorb_decoded(input logic [7:0] b, inout bit got, inout escf_result_t r);
		if (dec_cnt >= DECODE_LIM) begin
			dec_cnt = DECODE_LIM + 8'd1;
		end else begin
			case (dec_cnt)
				8'd0: src_reg = b;
				8'd1: dst_reg = b;
				8'd2: addr_reg[7:0] = b;
				8'd3: addr_reg[15:8] = b;
				default: begin
					got = 1'b1;
					r.data_byte = b;
				end
			endcase
			dec_cnt = dec_cnt + 8'd1;
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit got, output escf_result_t r);
		logic [7:0]   pos;
		logic [7:0]   plen;
		escf_status_t st;
		got = 1'b0;
		r = '0;
		if (!in_frame) begin
			if (b == BYTE_START) begin
				clear_frame();
				raw_cnt  = 8'd1;
				in_frame = 1'b1;
			end
		end else if (raw_cnt >= MAX_FRAME) begin
			// overrun: byte dropped, abort reported so the consumer discards
			in_frame = 1'b0;
			clear_frame();
			got = 1'b1;
			r.is_end = 1'b1;
			r.status = ST_OVERFLOW;
		end else begin
			pos = raw_cnt;
			raw_cnt = pos + 8'd1;
			if (b == BYTE_END) begin
				if (raw_cnt < 8'd4)
					st = ST_SHORT;
				else if (esc_err || esc_pend)
					st = ST_BAD_ESC;
				else if (dec_cnt > DECODE_LIM || dec_cnt != decl_len)
					st = ST_LEN_MISM;
				else if (dec_cnt < HEADER_LEN)
					st = ST_NO_HEADER;
				else
					st = ST_OK;
				got = 1'b1;
				r.is_end = 1'b1;
				r.status = st;
				if (st == ST_OK) begin
					plen = dec_cnt - HEADER_LEN;
					r.src_port    = src_reg;
					r.dst_port    = dst_reg;
					r.remote_addr = addr_reg;
					r.body_len    = plen[6:0];
				end
				in_frame = 1'b0;
				clear_frame();
			end else if (pos == 8'd1) begin
				decl_len = b;
			end else if (esc_err || dec_cnt > DECODE_LIM) begin
				// sticky: nothing decoded until the frame ends
			end else if (esc_pend) begin
				esc_pend = 1'b0;
				if (b == ESC_FF)
					absorb_decoded(8'hFF, got, r);
				else if (b == ESC_FE)
					absorb_decoded(8'hFE, got, r);
				else
					esc_err = 1'b1;
			end else if (b == BYTE_START) begin
				esc_pend = 1'b1;
			end else begin
				absorb_decoded(b, got, r);
			end
		end
	endtask

	task automatic check_field(input string fname, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s expected %h, got %h", $time, fname, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_frame = 1'b0;
			clear_frame();
			predicted_results.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (predicted_results.size() == 0) begin
					fail_count++;
					$display("%0t: result expected none, got is_end %b data %h status %0d",
						$time, res_is_end, res_data_byte, res_status);
				end else begin
					want = predicted_results.pop_front();
					check_field("is_end", want.is_end, res_is_end);
					check_field("data_byte", want.data_byte, res_data_byte);
					check_field("src_port", want.src_port, res_src_port);
					check_field("dst_port", want.dst_port, res_dst_port);
					check_field("remote_addr", want.remote_addr, res_remote_addr);
					check_field("body_len", want.body_len, res_body_len);
					check_field("status", want.status, res_status);
				end
			end
			if (rx_valid && rx_ready) begin
				deframe_byte(rx_byte, emits, fresh);
				if (emits)
					predicted_results.push_back(fresh);
			end
		end
		n_pending = predicted_results.size();
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: link byte stimulus, result backpressure and verdict for the escaped
// frame receiver. Depends on escf_pkg, escf_if and frame_result_checker.
module tb_top import escf_pkg::*;;

	localparam int MAX_FRAME   = 128;
	localparam int N_ITEMS     = 1750;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN       = 20;

	localparam logic [7:0] DIRECTED [29] = '{
		8'h00,
		BYTE_START, BYTE_END,
		BYTE_START, 8'h01, 8'h11, BYTE_END,
		BYTE_START, 8'h05, BYTE_START, ESC_FF, BYTE_START, ESC_FE, 8'h00,
		BYTE_START, ESC_FF, 8'h80, BYTE_END,
		BYTE_START, 8'h04, BYTE_START, 8'h11, BYTE_END,
		BYTE_START, 8'h00, 8'h01, 8'h02, BYTE_START, BYTE_END
	};

	logic clk;
	logic arst_n;

	escf_rx_if  rx_if ();
	escf_res_if res_if ();

	int fail_count;
	int n_pending;
	int cycle_cnt = 0;
	int idle_pct;
	int stall_pct;
	int frame_bytes = 0;
	int frame_no = 0;
	int phase;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	logic [7:0] link_bytes[$];

	escaped_frame_receiver #(
		.MAX_FRAME(MAX_FRAME)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.res   (res_if)
	);

	frame_result_checker #(
		.MAX_FRAME(MAX_FRAME)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_if.valid),
		.rx_ready       (rx_if.ready),
		.rx_byte        (rx_if.rx_byte),
		.res_valid      (res_if.valid),
		.res_ready      (res_if.ready),
		.res_is_end     (res_if.is_end),
		.res_data_byte  (res_if.data_byte),
		.res_src_port   (res_if.src_port),
		.res_dst_port   (res_if.dst_port),
		.res_remote_addr(res_if.remote_addr),
		.res_body_len   (res_if.body_len),
		.res_status     (res_if.status),
		.fail_count     (fail_count),
		.n_pending      (n_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// data byte biased toward the framing codes, or free of them when plain is set
	function automatic logic [7:0] pick_byte(input bit plain);
		int r;
		r = $urandom_range(0, 7);
		if (plain)
			return 8'($urandom_range(0, 8'hFD));
		if (r == 0)
			return BYTE_START;
		if (r == 1)
			return BYTE_END;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic put_escaped(input logic [7:0] b);
		if (b == BYTE_END) begin
			link_bytes.push_back(BYTE_START);
			link_bytes.push_back(ESC_FF);
		end else if (b == BYTE_START) begin
			link_bytes.push_back(BYTE_START);
			link_bytes.push_back(ESC_FE);
		end else begin
			link_bytes.push_back(b);
		end
	endtask

	task automatic put_bad_escape();
		logic [7:0] x;
		x = 8'($urandom_range(0, 255));
		while (x == ESC_FF || x == ESC_FE)
			x = 8'($urandom_range(0, 255));
		link_bytes.push_back(BYTE_START);
		link_bytes.push_back(x);
	endtask

	task automatic build_frame(input int nr);
		int         kind;
		int         n_pay;
		int         n_dec;
		int         bad_at;
		int         start_len;
		bit         big;
		bit         plain;
		logic [7:0] dec[$];
		kind      = $urandom_range(0, 99);
		big       = (nr % 25 == 3);
		plain     = big && ($urandom_range(0, 1) == 1);
		n_pay     = big ? $urandom_range(96, 121) : $urandom_range(0, 12);
		start_len = link_bytes.size();
		if (nr % 40 == 7) begin
			// runaway frame: never ends within the raw limit
			link_bytes.push_back(BYTE_START);
			link_bytes.push_back(8'($urandom_range(0, 8'hFD)));
			repeat (MAX_FRAME + 2)
				link_bytes.push_back(8'($urandom_range(0, 8'hFD)));
			link_bytes.push_back(BYTE_END);
			frame_bytes += MAX_FRAME;
		end else if (kind < 12) begin
			// idle noise, ignored by the block
			repeat ($urandom_range(1, 4))
				link_bytes.push_back(8'($urandom_range(0, 8'hFD)));
		end else begin
			n_dec = (kind < 20) ? $urandom_range(0, 3) : 4 + n_pay;
			repeat (n_dec)
				dec.push_back(pick_byte(plain));
			link_bytes.push_back(BYTE_START);
			if (kind >= 75 && kind < 85)
				link_bytes.push_back(pick_byte(1'b0));
			else
				link_bytes.push_back(8'(n_dec));
			bad_at = (kind >= 85 && kind < 93) ? $urandom_range(0, n_dec) : -1;
			for (int i = 0; i < n_dec; i++) begin
				if (i == bad_at)
					put_bad_escape();
				put_escaped(dec[i]);
			end
			if (bad_at == n_dec)
				put_bad_escape();
			if (kind >= 93)
				link_bytes.push_back(BYTE_START);
			link_bytes.push_back(BYTE_END);
			frame_bytes += link_bytes.size() - start_len;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
	endtask

	initial begin
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		res_if.ready  = 1'b0;
		arst_n        = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		while (frame_bytes < N_ITEMS) begin
			phase = frame_bytes * 5 / N_ITEMS;
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				3: begin idle_pct = 7;  stall_pct = 7;  end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_req  = 1'b1;
				end
			endcase
			build_frame(frame_no);
			frame_no++;
			while (link_bytes.size() > 0)
				send_byte(link_bytes.pop_front());
		end
		rx_if.valid <= 1'b0;

		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
